/* design/msbs_pkg.sv */
// Package for the motor stop / brake sequencer.
// Holds request and result structs, config struct, register indexes and phase codes.
// No dependencies.
package msbs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TICK_W     = 17;
    localparam int SQ_TERM_W  = 31;
    localparam int SQ_W       = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_STOP_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSERVER_SELECT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_MIN_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_MIN_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_MAX_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CURRENT_SQ    = 3'd5;

    localparam logic [1:0] OBS_ENCODER = 2'd0;
    localparam logic [1:0] OBS_SMO     = 2'd1;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    typedef enum logic [1:0] {
        PH_INIT  = 2'd0,
        PH_BRAKE = 2'd1,
        PH_DONE  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SUB_ZERO_DRIVE = 2'd0,
        SUB_MIN_WAIT   = 2'd1,
        SUB_DECAY      = 2'd2
    } t_substep;

    typedef struct packed {
        logic               command;
        logic               startup_done;
        logic signed [15:0] speed_est;
        logic signed [15:0] current_alpha;
        logic signed [15:0] current_beta;
        logic        [15:0] angle_encoder;
        logic        [15:0] angle_smo;
        logic        [15:0] angle_flux;
    } t_in;

    typedef struct packed {
        logic [15:0] drive_angle;
        logic        disable_loops;
        logic        fast_stop;
        logic        zero_drive;
        logic        restart_current_loop;
        logic [1:0]  stop_phase;
        logic [1:0]  brake_substep;
    } t_out;

    typedef struct packed {
        logic               brake_stop_enable;
        logic [1:0]         observer_select;
        logic signed [15:0] brake_min_speed;
        logic [15:0]        brake_min_ticks;
        logic [15:0]        brake_max_ticks;
        logic [31:0]        end_current_sq;
    } t_cfg;

endpackage

/* design/msbs_cfg.sv */
// Configuration register file for the motor stop / brake sequencer.
// Depends on msbs_pkg (t_cfg, register indexes).
module msbs_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr,
    input  logic [msbs_pkg::CFG_IDX_W-1:0]      i_index,
    input  logic [msbs_pkg::CFG_DATA_W-1:0]     i_data,
    output msbs_pkg::t_cfg                      o_cfg
);

    msbs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brake_stop_enable <= 1'b0;
            r_cfg.observer_select   <= 2'd0;
            r_cfg.brake_min_speed   <= 16'sd0;
            r_cfg.brake_min_ticks   <= 16'd0;
            r_cfg.brake_max_ticks   <= 16'hFFFF;
            r_cfg.end_current_sq    <= 32'd0;
        end else if (i_wr) begin
            unique case (i_index)
                msbs_pkg::CFG_BRAKE_STOP_ENABLE: r_cfg.brake_stop_enable <= i_data[0];
                msbs_pkg::CFG_OBSERVER_SELECT:   r_cfg.observer_select   <= i_data[1:0];
                msbs_pkg::CFG_BRAKE_MIN_SPEED:   r_cfg.brake_min_speed   <= i_data[15:0];
                msbs_pkg::CFG_BRAKE_MIN_TICKS:   r_cfg.brake_min_ticks   <= i_data[15:0];
                msbs_pkg::CFG_BRAKE_MAX_TICKS:   r_cfg.brake_max_ticks   <= i_data[15:0];
                msbs_pkg::CFG_END_CURRENT_SQ:    r_cfg.end_current_sq    <= i_data;
                default: ; // unknown index: drop the write
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/msbs_sq.sv */
// Input stage: registers the request and the two squared current terms.
// Depends on msbs_pkg (t_in, widths).
module msbs_sq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic                                i_drain,
    input  msbs_pkg::t_in                       i_req,
    output logic                                o_valid,
    output msbs_pkg::t_in                       o_req,
    output logic [msbs_pkg::SQ_TERM_W-1:0]      o_sq_alpha,
    output logic [msbs_pkg::SQ_TERM_W-1:0]      o_sq_beta
);

    logic                              r_valid;
    msbs_pkg::t_in                     r_req;
    logic [msbs_pkg::SQ_TERM_W-1:0]    r_sq_alpha;
    logic [msbs_pkg::SQ_TERM_W-1:0]    r_sq_beta;
    logic signed [31:0]                n_sq_alpha;
    logic signed [31:0]                n_sq_beta;

    // squares of Q1.15 values are non-negative and at most 2^30
    assign n_sq_alpha = i_req.current_alpha * i_req.current_alpha;
    assign n_sq_beta  = i_req.current_beta * i_req.current_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req      <= i_req;
            r_sq_alpha <= n_sq_alpha[msbs_pkg::SQ_TERM_W-1:0];
            r_sq_beta  <= n_sq_beta[msbs_pkg::SQ_TERM_W-1:0];
        end
    end

    assign o_valid    = r_valid;
    assign o_req      = r_req;
    assign o_sq_alpha = r_sq_alpha;
    assign o_sq_beta  = r_sq_beta;

endmodule

/* design/msbs_core.sv */
// Stop sequencer state machine and result register.
// Depends on msbs_pkg (t_in, t_out, t_cfg, phase and substep enums).
module msbs_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic                                i_out_take,
    input  msbs_pkg::t_cfg                      i_cfg,
    input  msbs_pkg::t_in                       i_req,
    input  logic [msbs_pkg::SQ_TERM_W-1:0]      i_sq_alpha,
    input  logic [msbs_pkg::SQ_TERM_W-1:0]      i_sq_beta,
    output logic                                o_valid,
    output msbs_pkg::t_out                      o_res
);

    msbs_pkg::t_phase                r_phase;
    msbs_pkg::t_phase                n_phase;
    msbs_pkg::t_phase                cur_phase;
    msbs_pkg::t_substep              r_substep;
    msbs_pkg::t_substep              n_substep;
    logic [msbs_pkg::TICK_W-1:0]     r_tick;
    logic [msbs_pkg::TICK_W-1:0]     n_tick;
    logic [msbs_pkg::TICK_W-1:0]     tick_inc;
    logic [msbs_pkg::SQ_W-1:0]       sq_sum;
    logic                            r_valid;
    msbs_pkg::t_out                  r_res;
    msbs_pkg::t_out                  n_res;

    assign sq_sum   = {1'b0, i_sq_alpha} + {1'b0, i_sq_beta};
    assign tick_inc = (r_tick == msbs_pkg::TICK_MAX) ? r_tick : r_tick + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_substep = r_substep;
        n_tick    = r_tick;
        n_res     = '0;

        unique case (i_cfg.observer_select)
            msbs_pkg::OBS_ENCODER: n_res.drive_angle = i_req.angle_encoder;
            msbs_pkg::OBS_SMO:     n_res.drive_angle = i_req.angle_smo;
            default:               n_res.drive_angle = i_req.angle_flux;
        endcase

        // begin-stop forces the initialize phase before stepping
        cur_phase = i_req.command ? msbs_pkg::PH_INIT : r_phase;
        n_phase   = cur_phase;

        if (!i_req.startup_done) begin
            n_res.disable_loops = 1'b1;
            n_res.fast_stop     = 1'b1;
            n_phase             = msbs_pkg::PH_DONE;
        end else begin
            unique case (cur_phase)
                msbs_pkg::PH_INIT: begin
                    n_tick = '0;
                    if (!i_cfg.brake_stop_enable) begin
                        n_res.fast_stop = 1'b1;
                        n_phase         = msbs_pkg::PH_DONE;
                    end else if (i_req.speed_est < i_cfg.brake_min_speed) begin
                        n_res.disable_loops = 1'b1;
                        n_res.fast_stop     = 1'b1;
                        n_phase             = msbs_pkg::PH_DONE;
                    end else begin
                        n_phase   = msbs_pkg::PH_BRAKE;
                        n_substep = msbs_pkg::SUB_ZERO_DRIVE;
                    end
                end
                msbs_pkg::PH_BRAKE: begin
                    unique case (r_substep)
                        msbs_pkg::SUB_ZERO_DRIVE: begin
                            n_res.disable_loops = 1'b1;
                            n_res.zero_drive    = 1'b1;
                            n_tick              = '0;
                            n_substep           = msbs_pkg::SUB_MIN_WAIT;
                        end
                        msbs_pkg::SUB_MIN_WAIT: begin
                            n_tick = tick_inc;
                            if (tick_inc > {1'b0, i_cfg.brake_min_ticks}) begin
                                n_tick    = '0;
                                n_substep = msbs_pkg::SUB_DECAY;
                            end
                        end
                        default: begin
                            n_tick = tick_inc;
                            if (sq_sum <= i_cfg.end_current_sq ||
                                tick_inc >= {1'b0, i_cfg.brake_max_ticks}) begin
                                n_res.restart_current_loop = 1'b1;
                                n_phase                    = msbs_pkg::PH_DONE;
                            end
                        end
                    endcase
                end
                default: begin
                    n_res.disable_loops = 1'b1;
                    n_res.fast_stop     = 1'b1;
                end
            endcase
        end

        n_res.stop_phase    = n_phase;
        n_res.brake_substep = n_substep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= msbs_pkg::PH_DONE;
            r_substep <= msbs_pkg::SUB_ZERO_DRIVE;
            r_tick    <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_step) begin
                r_phase   <= n_phase;
                r_substep <= n_substep;
                r_tick    <= n_tick;
                r_valid   <= 1'b1;
            end else if (i_out_take) begin
                r_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* design/motor_stop_brake_sequencer_top.sv */
// Top level of the motor stop / brake sequencer.
// Depends on msbs_pkg, msbs_cfg, msbs_sq and msbs_core.
//
// Usage:
//   Request channel: i_in_valid / o_in_stall carry one control-tick request
//   (i_in). A request is taken at a clock edge with valid high and stall low.
//   Result channel: o_out_valid / i_out_stall carry one result per request
//   (o_out), taken at an edge with valid high and stall low.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
//   ready is always high. Write only while no request is in flight.
// Timing:
//   Two register stages: the input stage registers the request and the two
//   squared current terms, the sequencer stage steps the state and registers
//   the result. One request per cycle is sustained while the result is not stalled.
// Reset (synchronous, active low): both stages empty, phase finished,
//   substep zero drive, tick counter zero, registers at their defaults.
// Stall: when the result is held, the result stage holds, the input stage
//   fills and then o_in_stall rises until the result is taken.
module motor_stop_brake_sequencer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  msbs_pkg::t_in                       i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output msbs_pkg::t_out                      o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [msbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [msbs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    msbs_pkg::t_cfg                    cfg;
    msbs_pkg::t_in                     s1_req;
    logic [msbs_pkg::SQ_TERM_W-1:0]    s1_sq_alpha;
    logic [msbs_pkg::SQ_TERM_W-1:0]    s1_sq_beta;
    logic                              s1_valid;
    logic                              out_valid;
    logic                              out_free;
    logic                              step;
    logic                              in_take;

    // the result slot is free when empty or being taken this cycle
    assign out_free    = !out_valid || !i_out_stall;
    assign step        = s1_valid && out_free;
    // the input stage accepts when empty or when its request advances
    assign o_in_stall  = s1_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = out_valid;

    msbs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    msbs_sq u_sq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_take),
        .i_drain    (step),
        .i_req      (i_in),
        .o_valid    (s1_valid),
        .o_req      (s1_req),
        .o_sq_alpha (s1_sq_alpha),
        .o_sq_beta  (s1_sq_beta)
    );

    msbs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_out_take (out_valid && !i_out_stall),
        .i_cfg      (cfg),
        .i_req      (s1_req),
        .i_sq_alpha (s1_sq_alpha),
        .i_sq_beta  (s1_sq_beta),
        .o_valid    (out_valid),
        .o_res      (o_out)
    );

endmodule
